/* rtl/core/fvg_pkg.sv */
// ----------------------------------------------------------------------------
// fvg_pkg
// Shared types, codes, stop tables, the LED bar and CC status functions of the
// fader glide engine.
// ----------------------------------------------------------------------------
package fvg_pkg;

  localparam int NUM_BANKS_C = 2;
  localparam int DIVIDEND_W  = 14;
  localparam int DIVISOR_W   = 11;

  // input item function codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PAD  = 2'd1;
  localparam logic [1:0] FUNC_MIDI = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_BANK = 2'd0;
  localparam logic [1:0] CFG_PAN_MASK0   = 2'd1;
  localparam logic [1:0] CFG_PAN_MASK1   = 2'd2;

  localparam logic [3:0] MIDI_TYPE_CC   = 4'hB;
  localparam logic [7:0] CC_STATUS_BASE = 8'hB0;
  localparam logic [6:0] CC_NUMBER_BASE = 7'd21;
  localparam logic [3:0] PAD_EDGE_LO    = 4'd0;
  localparam logic [3:0] PAD_EDGE_HI    = 4'd9;

  // glide time = (GLIDE_BASE - GLIDE_SLOPE * velocity) / 7, taken as a multiply
  // by GLIDE_RECIP and a right shift by GLIDE_SHIFT; exact for every dividend
  // up to GLIDE_BASE
  localparam logic [DIVIDEND_W-1:0] GLIDE_BASE  = 14'd14110;
  localparam logic [DIVIDEND_W-1:0] GLIDE_SLOPE = 14'd110;
  localparam logic [14:0]           GLIDE_RECIP = 15'd18725;
  localparam int                    GLIDE_SHIFT = 17;

  localparam logic [6:0] LIN_STOPS [0:7] = '{7'd0, 7'd17, 7'd34, 7'd52,
                                             7'd70, 7'd89, 7'd108, 7'd127};
  localparam logic [6:0] PAN_STOPS [0:7] = '{7'd0, 7'd21, 7'd42, 7'd63,
                                             7'd64, 7'd85, 7'd106, 7'd127};

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       send_cc;
    logic       cc_port;
    logic [7:0] cc_status;
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic       has_bar;
    logic [2:0] bar_row;
    logic [7:0] bar_mask;
    logic       last;
  } out_rec_t;

  function automatic logic [7:0] bar_of(input logic [6:0] v, input logic pan);
    logic [7:0] m;
    m = '0;
    if (!pan) begin
      for (int x = 0; x < 8; x++) begin
        if (v >= LIN_STOPS[x] && v != 7'd0) m[x] = 1'b1;
      end
    end else if (v < PAN_STOPS[3]) begin
      for (int x = 0; x < 4; x++) begin
        if (v <= PAN_STOPS[x]) m[x] = 1'b1;
      end
    end else if (v > PAN_STOPS[4]) begin
      for (int x = 4; x < 8; x++) begin
        if (v >= PAN_STOPS[x]) m[x] = 1'b1;
      end
    end else begin
      m = 8'h18;
    end
    return m;
  endfunction

  function automatic logic [7:0] cc_status_of(input logic bank);
    return CC_STATUS_BASE + {6'd0, ~bank, 1'b0};
  endfunction

endpackage

/* rtl/core/fvg_if.sv */
// ----------------------------------------------------------------------------
// fvg_if
// Valid/ready channels of the fader glide engine: input items, result items
// and configuration writes.
// ----------------------------------------------------------------------------
interface fvg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] pad_col;
  logic [3:0] pad_row;
  logic [6:0] key_number;
  logic [6:0] key_value;
  logic [1:0] in_port;
  logic [3:0] in_type;
  logic [3:0] in_channel;

  modport source (output valid, func, pad_col, pad_row, key_number, key_value,
                  in_port, in_type, in_channel, input ready);
  modport sink   (input valid, func, pad_col, pad_row, key_number, key_value,
                  in_port, in_type, in_channel, output ready);
endinterface

interface fvg_out_if;
  logic       valid;
  logic       ready;
  logic       send_cc;
  logic       cc_port;
  logic [7:0] cc_status;
  logic [6:0] cc_number;
  logic [6:0] cc_value;
  logic       has_bar;
  logic [2:0] bar_row;
  logic [7:0] bar_mask;
  logic       last;

  modport source (output valid, send_cc, cc_port, cc_status, cc_number, cc_value,
                  has_bar, bar_row, bar_mask, last, input ready);
  modport sink   (input valid, send_cc, cc_port, cc_status, cc_number, cc_value,
                  has_bar, bar_row, bar_mask, last, output ready);
endinterface

interface fvg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fvg_div.sv */
// ----------------------------------------------------------------------------
// fvg_div
// Shared restoring divider: one quotient bit per cycle, done pulses with the
// final quotient.
// ----------------------------------------------------------------------------
module fvg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fvg_pkg::div_req_t req,
  output fvg_pkg::div_rsp_t rsp
);
  import fvg_pkg::*;

  localparam logic [3:0] LAST_CNT = 4'(DIVIDEND_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [3:0]            cnt_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    sub;
  logic                  ge;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign sub   = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == LAST_CNT);
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when it fits
        rem_r <= ge ? sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/core/velocity_fader_glide_engine.sv */
// ----------------------------------------------------------------------------
// velocity_fader_glide_engine
// Two banks of faders with velocity-timed glides, pad echo and control-change
// follow; results carry a control change, an LED bar redraw or both.
// ----------------------------------------------------------------------------
//
//   channel   | dir | handshake         | payload
//   ----------+-----+-------------------+-------------------------------------
//   in_item   | in  | valid & ready     | func, pad, key, MIDI header fields
//   out_item  | out | valid & ready     | control change, LED bar, last
//   cfg_wr    | in  | valid & ready (=1)| register index, 8-bit data
//
// During a timer tick the sequencer visits one fader per cycle unless the scan
// stalls. A grid pad press that starts a glide waits on the shared divider,
// which forms the step period or step size; the glide time itself comes from
// one reciprocal multiply. Reset clears all fader state at once.
// A full output register stalls the scan only when a second result is ready.
// ----------------------------------------------------------------------------
module velocity_fader_glide_engine #(
  parameter int NUM_FADERS = 8
) (
  input logic       clk,
  input logic       rst_n,
  fvg_in_if.sink    in_item,
  fvg_out_if.source out_item,
  fvg_cfg_if.sink   cfg_wr
);
  import fvg_pkg::*;

  localparam int         FIW      = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;
  localparam logic [2:0] LAST_Y   = 3'(NUM_FADERS - 1);
  localparam logic [3:0] NF_ROW   = 4'(NUM_FADERS);
  localparam logic [6:0] KEY_LAST = 7'(20 + NUM_FADERS);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DIV_T, S_DIV_Q_START, S_DIV_Q, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic       ab_r;
  logic [7:0] pan_r [NUM_BANKS_C];

  // per-bank, per-fader glide state
  logic [6:0]  fval_r [NUM_BANKS_C][NUM_FADERS];
  logic [6:0]  ftgt_r [NUM_BANKS_C][NUM_FADERS];
  logic [6:0]  fstp_r [NUM_BANKS_C][NUM_FADERS];
  logic [10:0] fper_r [NUM_BANKS_C][NUM_FADERS];
  logic [10:0] fte_r  [NUM_BANKS_C][NUM_FADERS];
  logic [7:0]  fdlt_r [NUM_BANKS_C][NUM_FADERS];

  // captured input item
  logic [1:0] func_r;
  logic [3:0] col_r, row_r;
  logic [6:0] key_r, kv_r;
  logic [1:0] port_r;
  logic [3:0] type_r, chan_r;

  // sequencer working registers
  logic [2:0]  fy_r;
  logic [6:0]  diff_r;
  logic        up_r;
  logic [10:0] t_r;
  logic [DIVIDEND_W-1:0] gdiv_r;
  logic [DIVIDEND_W+14:0] t_prod;

  // result path: pending result, then output register
  out_rec_t pend_r, out_r;
  logic     pend_v_r, out_v_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  fvg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // current fader
  logic [FIW-1:0] fi;
  logic [6:0]     cur_val, cur_tgt, cur_stp;
  logic [10:0]    cur_per, cur_te;
  logic [7:0]     cur_dlt;
  logic           pan_bit;

  assign fi      = fy_r[FIW-1:0];
  assign cur_val = fval_r[ab_r][fi];
  assign cur_tgt = ftgt_r[ab_r][fi];
  assign cur_stp = fstp_r[ab_r][fi];
  assign cur_per = fper_r[ab_r][fi];
  assign cur_te  = fte_r[ab_r][fi];
  assign cur_dlt = fdlt_r[ab_r][fi];
  assign pan_bit = pan_r[ab_r][fy_r];

  // glide time: divide by seven through the reciprocal
  assign t_prod = {15'd0, gdiv_r} * {14'd0, GLIDE_RECIP};

  // tick step of the current fader
  logic [10:0] te_n;
  logic [6:0]  stp_n, val_n;
  logic        fire, out_free, scan_stall, scan_go, out_load;
  out_rec_t    scan_rec, pend_last;

  assign te_n  = cur_te + 11'd1;
  assign fire  = (cur_stp != 7'd0) && (te_n >= cur_per);
  assign stp_n = cur_stp - 7'd1;
  // snap to target on the last step
  assign val_n = (stp_n == 7'd0) ? cur_tgt : cur_val + cur_dlt[6:0];

  assign out_free   = !out_v_r || out_item.ready;
  assign scan_stall = fire && pend_v_r && !out_free;
  assign scan_go    = (state_r == S_SCAN) && !scan_stall;
  // output register takes a new item this cycle
  assign out_load   = (scan_go && fire && pend_v_r) ||
                      ((state_r == S_FLUSH) && pend_v_r && out_free);

  always_comb begin
    scan_rec           = '0;
    scan_rec.send_cc   = 1'b1;
    scan_rec.cc_port   = ab_r;
    scan_rec.cc_status = cc_status_of(ab_r);
    scan_rec.cc_number = CC_NUMBER_BASE + {4'd0, fy_r};
    scan_rec.cc_value  = val_n;
    scan_rec.has_bar   = 1'b1;
    scan_rec.bar_row   = fy_r;
    scan_rec.bar_mask  = bar_of(val_n, pan_bit);

    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  // decode of a pad or MIDI item
  logic       pad_ign, pad_edge, pad_grid, midi_hit;
  logic [2:0] xx;
  logic [6:0] tgt, diff;
  logic       up;
  out_rec_t   echo_rec, resend_rec, midi_rec;

  assign pad_ign  = (key_r == 7'd0) || (col_r > PAD_EDGE_HI) || (row_r > PAD_EDGE_HI);
  assign pad_edge = (col_r == PAD_EDGE_LO) || (col_r == PAD_EDGE_HI) ||
                    (row_r == PAD_EDGE_LO) || (row_r == PAD_EDGE_HI);
  assign pad_grid = (kv_r != 7'd0) && (row_r <= NF_ROW);
  assign midi_hit = (port_r == {1'b0, ab_r}) && (type_r == MIDI_TYPE_CC) &&
                    (chan_r == {2'b00, ~ab_r, 1'b0}) &&
                    (key_r >= CC_NUMBER_BASE) && (key_r <= KEY_LAST);

  assign xx   = 3'(col_r - 4'd1);
  assign tgt  = pan_bit ? PAN_STOPS[xx] : LIN_STOPS[xx];
  assign up   = cur_val < tgt;
  assign diff = up ? tgt - cur_val : cur_val - tgt;

  always_comb begin
    echo_rec           = '0;
    echo_rec.send_cc   = 1'b1;
    echo_rec.cc_port   = ab_r;
    echo_rec.cc_status = cc_status_of(ab_r);
    echo_rec.cc_number = key_r;
    echo_rec.cc_value  = kv_r;

    resend_rec           = echo_rec;
    resend_rec.cc_number = CC_NUMBER_BASE + {4'd0, fy_r};
    resend_rec.cc_value  = cur_val;

    midi_rec          = '0;
    midi_rec.has_bar  = 1'b1;
    midi_rec.bar_row  = fy_r;
    midi_rec.bar_mask = bar_of(kv_r, pan_bit);
  end

  // divider request: step period or step size from the glide time
  logic t_ge;
  assign t_ge = t_r >= {4'd0, diff_r};

  always_comb begin
    div_req = '0;
    if (state_r == S_DIV_Q_START) begin
      div_req.start = 1'b1;
      if (t_ge) begin
        div_req.dividend = {3'd0, t_r};
        div_req.divisor  = {4'd0, diff_r};
      end else begin
        div_req.dividend = {7'd0, diff_r};
        div_req.divisor  = t_r;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          if (in_item.func == FUNC_TICK) state_nxt = S_SCAN;
          else if (in_item.func == FUNC_PAD || in_item.func == FUNC_MIDI)
            state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (func_r == FUNC_PAD) begin
          if (pad_ign) state_nxt = S_IDLE;
          else if (pad_edge) state_nxt = S_FLUSH;
          else if (pad_grid) state_nxt = (diff == 7'd0) ? S_FLUSH : S_DIV_T;
        end else if (midi_hit) begin
          state_nxt = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (scan_go && fy_r == LAST_Y) state_nxt = S_FLUSH;
      end
      S_DIV_T: state_nxt = S_DIV_Q_START;
      S_DIV_Q_START: state_nxt = S_DIV_Q;
      S_DIV_Q: begin
        if (div_rsp.done) state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_item.ready = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ab_r     <= 1'b0;
      pan_r[0] <= '0;
      pan_r[1] <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_ACTIVE_BANK: ab_r     <= cfg_wr.data[0];
          CFG_PAN_MASK0:   pan_r[0] <= cfg_wr.data;
          CFG_PAN_MASK1:   pan_r[1] <= cfg_wr.data;
          default: ;
        endcase
      end

      // drop the output item once taken, unless a new one replaces it
      if (out_v_r && out_item.ready && !out_load) out_v_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_item.valid) begin
            func_r <= in_item.func;
            col_r  <= in_item.pad_col;
            row_r  <= in_item.pad_row;
            key_r  <= in_item.key_number;
            kv_r   <= in_item.key_value;
            port_r <= in_item.in_port;
            type_r <= in_item.in_type;
            chan_r <= in_item.in_channel;
            if (in_item.func == FUNC_PAD) fy_r <= 3'(in_item.pad_row - 4'd1);
            else if (in_item.func == FUNC_MIDI)
              fy_r <= 3'(in_item.key_number - CC_NUMBER_BASE);
            else fy_r <= 3'd0;
          end
        end
        S_DECODE: begin
          diff_r <= diff;
          up_r   <= up;
          gdiv_r <= GLIDE_BASE - 14'(GLIDE_SLOPE * {7'd0, kv_r});
          if (func_r == FUNC_PAD) begin
            if (!pad_ign && pad_edge) begin
              pend_r   <= echo_rec;
              pend_v_r <= 1'b1;
            end else if (!pad_ign && pad_grid && diff == 7'd0) begin
              pend_r   <= resend_rec;
              pend_v_r <= 1'b1;
            end
          end else if (midi_hit) begin
            pend_r   <= midi_rec;
            pend_v_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            fy_r <= fy_r + 3'd1;
            if (fire) begin
              // hold the new result; push the previous one as not last
              pend_r   <= scan_rec;
              pend_v_r <= 1'b1;
              if (pend_v_r) begin
                out_r   <= pend_r;
                out_v_r <= 1'b1;
              end
            end
          end
        end
        S_DIV_T: begin
          t_r <= t_prod[GLIDE_SHIFT +: 11];
        end
        S_FLUSH: begin
          if (pend_v_r && out_free) begin
            out_r    <= pend_last;
            out_v_r  <= 1'b1;
            pend_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // fader state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANKS_C; b++) begin
        for (int f = 0; f < NUM_FADERS; f++) begin
          fval_r[b][f] <= '0;
          ftgt_r[b][f] <= '0;
          fstp_r[b][f] <= '0;
          fper_r[b][f] <= '0;
          fte_r[b][f]  <= '0;
          fdlt_r[b][f] <= '0;
        end
      end
    end else begin
      if (scan_go && cur_stp != 7'd0) begin
        fte_r[ab_r][fi] <= fire ? 11'd0 : te_n;
        if (fire) begin
          fval_r[ab_r][fi] <= val_n;
          fstp_r[ab_r][fi] <= stp_n;
        end
      end
      if (state_r == S_DECODE) begin
        if (func_r == FUNC_PAD && !pad_ign && !pad_edge && pad_grid) begin
          ftgt_r[ab_r][fi] <= tgt;
          fte_r[ab_r][fi]  <= 11'd0;
        end else if (func_r == FUNC_MIDI && midi_hit) begin
          fstp_r[ab_r][fi] <= 7'd0;
          fval_r[ab_r][fi] <= kv_r;
        end
      end
      if (state_r == S_DIV_Q && div_rsp.done) begin
        if (t_ge) begin
          // one count per step, stepping every t/diff ticks
          fper_r[ab_r][fi] <= div_rsp.quotient[10:0];
          fstp_r[ab_r][fi] <= diff_r;
          fdlt_r[ab_r][fi] <= up_r ? 8'd1 : 8'hFF;
        end else begin
          // larger steps every tick
          fper_r[ab_r][fi] <= 11'd1;
          fstp_r[ab_r][fi] <= t_r[6:0];
          fdlt_r[ab_r][fi] <= up_r ? div_rsp.quotient[7:0] : 8'd0 - div_rsp.quotient[7:0];
        end
      end
    end
  end

  assign out_item.valid     = out_v_r;
  assign out_item.send_cc   = out_r.send_cc;
  assign out_item.cc_port   = out_r.cc_port;
  assign out_item.cc_status = out_r.cc_status;
  assign out_item.cc_number = out_r.cc_number;
  assign out_item.cc_value  = out_r.cc_value;
  assign out_item.has_bar   = out_r.has_bar;
  assign out_item.bar_row   = out_r.bar_row;
  assign out_item.bar_mask  = out_r.bar_mask;
  assign out_item.last      = out_r.last;

  // accepting an item implies no result is left pending
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.ready |-> !pend_v_r) else $error("pending result at idle");

  // a running glide always has a nonzero step period
  a_glide_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cur_stp != 7'd0) |-> cur_per != 11'd0)
    else $error("running glide with zero period");

  // divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV_Q))
    else $error("unexpected divider completion");

  // a scan result with a bar always sends its control change
  a_scan_cc: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_go && fire) |=> (pend_v_r && pend_r.send_cc && pend_r.has_bar))
    else $error("tick result lost its fields");

endmodule

/* sim/fvg_tb_if.sv */
// ----------------------------------------------------------------------------
// fvg_tb_if
// Testbench package: the input item record that the stimulus tasks build and
// send.
// ----------------------------------------------------------------------------
package fvg_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] pad_col;
    logic [3:0] pad_row;
    logic [6:0] key_number;
    logic [6:0] key_value;
    logic [1:0] in_port;
    logic [3:0] in_type;
    logic [3:0] in_channel;
  } fader_event_t;
endpackage

/* sim/tb_velocity_fader_glide_engine.sv */
// ----------------------------------------------------------------------------
// tb_velocity_fader_glide_engine
// Drives ticks, pad presses and incoming control changes into the fader glide
// engine, predicts every control change and LED bar redraw, and compares them.
// ----------------------------------------------------------------------------
module tb_velocity_fader_glide_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import fvg_pkg::*;
  import fvg_tb_pkg::*;

  localparam int NF = 8;
  localparam int LIMIT = 2000000;
  localparam int EV_W = $bits(fader_event_t);
  localparam logic [6:0] LIN_TAB [0:7] = '{0, 17, 34, 52, 70, 89, 108, 127};
  localparam logic [6:0] PAN_TAB [0:7] = '{0, 21, 42, 63, 64, 85, 106, 127};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  fvg_in_if  in_item();
  fvg_out_if out_item();
  fvg_cfg_if cfg_wr();

  velocity_fader_glide_engine #(.NUM_FADERS(NF)) dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .out_item(out_item),
    .cfg_wr(cfg_wr)
  );

  // predicted fader state, one slot per bank and fader
  logic       bank_sel;
  logic [7:0] pan_mask [0:1];
  logic [6:0] fval [0:15];
  logic [6:0] tval [0:15];
  logic [6:0] steps [0:15];
  logic [10:0] period [0:15];
  logic [10:0] ticks [0:15];
  logic [7:0] delta [0:15];

  out_rec_t pending_cc [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit in_held = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // compute the LED bar the way the fader displays it
  function automatic logic [7:0] led_bar(input logic [6:0] v, input logic pan);
    logic [7:0] m;
    m = '0;
    if (!pan) begin
      for (int x = 0; x < 8; x++) if (v >= LIN_TAB[x] && v != 0) m[x] = 1'b1;
    end else if (v < 63) begin
      for (int x = 0; x < 4; x++) if (v <= PAN_TAB[x]) m[x] = 1'b1;
    end else if (v > 64) begin
      for (int x = 4; x < 8; x++) if (v >= PAN_TAB[x]) m[x] = 1'b1;
    end else begin
      m = 8'h18;
    end
    return m;
  endfunction

  function automatic out_rec_t make_rec(input logic send, input logic [6:0] num,
      input logic [6:0] val, input logic bar, input logic [2:0] row,
      input logic [7:0] mask);
    out_rec_t r;
    r = '0;
    if (send) begin
      r.send_cc = 1'b1;
      r.cc_port = bank_sel;
      r.cc_status = bank_sel ? 8'hB0 : 8'hB2;
      r.cc_number = num;
      r.cc_value = val;
    end
    if (bar) begin
      r.has_bar = 1'b1;
      r.bar_row = row;
      r.bar_mask = mask;
    end
    return r;
  endfunction

  // advance the fader state for one item and queue the results it causes
  task automatic predict_fader(input fader_event_t e);
    out_rec_t res [$];
    int s, y, x, t, cur, tgt, diff, mag;
    logic up, pan;
    if (e.func == FUNC_TICK) begin
      for (y = 0; y < NF; y++) begin
        s = bank_sel * 8 + y;
        if (steps[s] == 0) continue;
        ticks[s] = ticks[s] + 11'd1;
        if (ticks[s] >= period[s]) begin
          fval[s] = fval[s] + delta[s][6:0];
          steps[s] = steps[s] - 7'd1;
          if (steps[s] == 0) fval[s] = tval[s];
          res.push_back(make_rec(1, 7'(21 + y), fval[s], 1, 3'(y),
                                 led_bar(fval[s], pan_mask[bank_sel][y])));
          ticks[s] = '0;
        end
      end
    end else if (e.func == FUNC_PAD) begin
      if (e.key_number == 0 || e.pad_col > 9 || e.pad_row > 9) begin
      end else if (e.pad_col == 0 || e.pad_col == 9 || e.pad_row == 0 ||
                   e.pad_row == 9) begin
        res.push_back(make_rec(1, e.key_number, e.key_value, 0, 0, 0));
      end else if (e.key_value != 0 && e.pad_row <= NF) begin
        x = e.pad_col - 1;
        y = e.pad_row - 1;
        s = bank_sel * 8 + y;
        pan = pan_mask[bank_sel][y];
        t = (14110 - 110 * e.key_value) / 7;
        tgt = pan ? PAN_TAB[x] : LIN_TAB[x];
        tval[s] = 7'(tgt);
        cur = fval[s];
        up = cur < tgt;
        diff = up ? tgt - cur : cur - tgt;
        ticks[s] = '0;
        if (diff == 0) begin
          res.push_back(make_rec(1, 7'(21 + y), 7'(cur), 0, 0, 0));
        end else if (t >= diff) begin
          period[s] = 11'(t / diff);
          steps[s] = 7'(diff);
          delta[s] = up ? 8'd1 : 8'hFF;
        end else begin
          mag = diff / t;
          period[s] = 11'd1;
          steps[s] = 7'(t);
          delta[s] = up ? 8'(mag) : 8'(256 - mag);
        end
      end
    end else if (e.func == FUNC_MIDI) begin
      if (e.in_port == {1'b0, bank_sel} && e.in_type == MIDI_TYPE_CC &&
          e.in_channel == (bank_sel ? 4'd0 : 4'd2) &&
          e.key_number >= 21 && e.key_number <= 20 + NF) begin
        y = e.key_number - 21;
        s = bank_sel * 8 + y;
        steps[s] = '0;
        fval[s] = e.key_value;
        res.push_back(make_rec(0, 0, 0, 1, 3'(y),
                               led_bar(fval[s], pan_mask[bank_sel][y])));
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_cc.push_back(res[i]);
  endtask

  // drop valid after the last accepted item
  task automatic release_input();
    if (in_held) begin
      in_item.valid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  // send one item; idle first as often as the current phase asks
  task automatic send_event(input fader_event_t e);
    while ($urandom_range(99) < send_idle) begin
      release_input();
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    {in_item.func, in_item.pad_col, in_item.pad_row, in_item.key_number,
     in_item.key_value, in_item.in_port, in_item.in_type,
     in_item.in_channel} <= e;
    do @(posedge clk); while (!in_item.ready);
    predict_fader(e);
    // valid stays high until the next item or an idle cycle replaces it
    in_held = 1'b1;
  endtask

  // receiver: stall at random, check each result against the oldest one due
  always @(posedge clk) begin
    if (out_item.valid && out_item.ready) begin
      out_rec_t got, want;
      got = '{out_item.send_cc, out_item.cc_port, out_item.cc_status,
              out_item.cc_number, out_item.cc_value, out_item.has_bar,
              out_item.bar_row, out_item.bar_mask, out_item.last};
      if (pending_cc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_cc.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, got %p", want, got);
        end
      end
    end
    out_item.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  task automatic drain();
    release_input();
    while (pending_cc.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    release_input();
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= d;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (idx == CFG_ACTIVE_BANK) bank_sel = d[0];
    else if (idx == CFG_PAN_MASK0) pan_mask[0] = d;
    else if (idx == CFG_PAN_MASK1) pan_mask[1] = d;
    @(posedge clk);
  endtask

  function automatic fader_event_t pad_ev(input int c, input int r, input int k,
                                          input int v);
    fader_event_t e;
    e = '{FUNC_PAD, 4'(c), 4'(r), 7'(k), 7'(v), 2'd0, 4'd0, 4'd0};
    return e;
  endfunction

  function automatic fader_event_t tick_ev();
    fader_event_t e;
    e = '0;
    e.func = FUNC_TICK;
    return e;
  endfunction

  function automatic fader_event_t cc_ev(input int k, input int v);
    fader_event_t e;
    e = '{FUNC_MIDI, 4'd0, 4'd0, 7'(k), 7'(v), {1'b0, bank_sel}, MIDI_TYPE_CC,
          bank_sel ? 4'd0 : 4'd2};
    return e;
  endfunction

  function automatic fader_event_t noise_ev();
    fader_event_t e;
    e = EV_W'({$urandom, $urandom});
    return e;
  endfunction

  // edge echoes, releases, pad index zero, out-of-grid pads, unknown func
  task automatic test_edges_and_ignored();
    fader_event_t e;
    send_event(pad_ev(0, 3, 127, 127));
    send_event(pad_ev(9, 9, 1, 0));
    send_event(pad_ev(4, 0, 64, 5));
    send_event(pad_ev(3, 3, 0, 100));
    send_event(pad_ev(3, 3, 30, 0));
    send_event(pad_ev(10, 3, 30, 9));
    send_event(pad_ev(15, 15, 127, 127));
    e = noise_ev();
    e.func = 2'd3;
    send_event(e);
    drain();
  endtask

  // fast glide (max velocity), slow glide (min velocity), press at target
  task automatic test_glides();
    send_event(pad_ev(8, 1, 11, 127));
    send_event(pad_ev(8, 2, 12, 1));
    send_event(pad_ev(1, 3, 13, 64));
    repeat (20) send_event(tick_ev());
    send_event(pad_ev(1, 2, 12, 127));
    repeat (30) send_event(tick_ev());
    drain();
  endtask

  // incoming control changes: matching, off-port, wrong channel, wrong type, edges of range
  task automatic test_cc_follow();
    fader_event_t e;
    send_event(cc_ev(21, 127));
    send_event(cc_ev(28, 0));
    send_event(cc_ev(20, 50));
    send_event(cc_ev(29, 50));
    e = cc_ev(22, 63);
    e.in_port = 2'd3;
    send_event(e);
    e = cc_ev(22, 63);
    e.in_channel = 4'd15;
    send_event(e);
    e = cc_ev(23, 64);
    e.in_type = 4'hA;
    send_event(e);
    send_event(cc_ev(22, 64));
    drain();
  endtask

  // mostly grid presses and ticks, some control changes and noise, across the idling phases
  task automatic test_random(input int count);
    fader_event_t e;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: e = pad_ev($urandom_range(1, 8), $urandom_range(1, 8),
                            $urandom_range(1, 127), $urandom_range(1, 127));
        3, 4, 5, 6: e = tick_ev();
        7: e = cc_ev($urandom_range(19, 30), $urandom_range(127));
        default: e = noise_ev();
      endcase
      send_event(e);
      case (i % 40)
        0: begin send_idle = 0; recv_stall = 0; end
        10: begin send_idle = 78; recv_stall = 0; end
        20: begin send_idle = 0; recv_stall = 78; end
        30: begin send_idle = 35; recv_stall = 35; end
        default: ;
      endcase
    end
    // hold off until every queued result has come back
    drain();
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    in_item.valid = 1'b0;
    {in_item.func, in_item.pad_col, in_item.pad_row, in_item.key_number,
     in_item.key_value, in_item.in_port, in_item.in_type,
     in_item.in_channel} = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    out_item.ready = 1'b0;
    bank_sel = 1'b0;
    pan_mask[0] = '0;
    pan_mask[1] = '0;
    for (int i = 0; i < 16; i++) begin
      fval[i] = '0; tval[i] = '0; steps[i] = '0;
      period[i] = '0; ticks[i] = '0; delta[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges_and_ignored();
    test_glides();
    test_cc_follow();
    write_reg(CFG_PAN_MASK0, 8'hFF);
    test_glides();
    test_random(50);
    write_reg(CFG_ACTIVE_BANK, 8'd1);
    write_reg(CFG_PAN_MASK1, 8'hA5);
    test_cc_follow();
    test_random(50);
    write_reg(CFG_PAN_MASK1, 8'h00);
    write_reg(CFG_PAN_MASK0, 8'h5A);
    test_random(40);
    write_reg(CFG_ACTIVE_BANK, 8'd0);
    test_random(50);
    repeat (40) @(posedge clk);

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
